// ----- rtl/fqlcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqlcg_pkg
// Shared types and constants for the FIFO queue with LCG batch fill.
// ----------------------------------------------------------------------------
package fqlcg_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SEED_W  = 31;
  localparam int unsigned SPAN_W  = 33;
  localparam int unsigned BIT_W   = 5;

  // input tdata: value, batch_count, range_min, range_max, start_seed
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned VAL_LSB    = 0;
  localparam int unsigned CNT_LSB    = 32;
  localparam int unsigned MIN_LSB    = 40;
  localparam int unsigned MAX_LSB    = 72;
  localparam int unsigned SEED_LSB   = 104;
  // output tdata: word_out, empty_flag, words_added, zero fill
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned EMPTY_BIT  = 32;
  localparam int unsigned ADDED_LSB  = 33;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 3'd0,
    OP_BATCH = 3'd1,
    OP_DEQ   = 3'd2,
    OP_FRONT = 3'd3,
    OP_EMPTY = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] word;
  } gen_stat_t;

endpackage

// ----- rtl/fqlcg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqlcg_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fqlcg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/fqlcg_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqlcg_gen
// LCG word generator: a multiply step, then a bit-serial remainder
// of the 31-bit seed by the range span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fqlcg_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fqlcg_pkg::gen_ctrl_t        ctrl,
  input  logic [fqlcg_pkg::WORD_W-1:0] range_min,
  input  logic [fqlcg_pkg::WORD_W-1:0] range_max,
  input  logic [fqlcg_pkg::WORD_W-1:0] start_seed,
  output fqlcg_pkg::gen_stat_t        stat
);
  import fqlcg_pkg::*;

  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [SEED_W-1:0] rem_r, rem_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] shifted;
  logic              ge;

  assign prod    = {1'b0, seed_r} * LCG_MUL + LCG_ADD;
  assign shifted = {rem_r, seed_r[bit_r]};
  assign ge      = {1'b0, shifted} >= span_r;

  always_comb begin
    seed_nxt = seed_r;
    rem_nxt  = rem_r;
    span_nxt = span_r;
    lo_nxt   = lo_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.load) begin
      seed_nxt = start_seed[SEED_W-1:0];
      lo_nxt   = range_min;
      // width of the span only; validity is checked by the caller
      span_nxt = SPAN_W'({range_max[WORD_W-1], range_max}
                         - {range_min[WORD_W-1], range_min} + 33'd1);
    end else if (ctrl.step) begin
      seed_nxt = prod[SEED_W-1:0];
      rem_nxt  = '0;
      bit_nxt  = BIT_W'(SEED_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SEED_W'(shifted - span_r[WORD_W-1:0]) : SEED_W'(shifted);
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    seed_r <= seed_nxt;
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    lo_r   <= lo_nxt;
    bit_r  <= bit_nxt;
  end

  assign stat.done = done_r;
  assign stat.word = lo_r + {1'b0, rem_r};

endmodule

// ----- rtl/fifo_queue_with_lcg_batch_fill_unit.sv -----
`timescale 1ns / 1ps
// Steps: dequeue and front add one RAM read; batch runs the generator once per
//   stored word, with its 31-step bit-serial remainder each time, and stops
//   early on a full queue.
// Throughput: one transaction in flight; the next is taken once the result
//   sits in the output register.
// Reset: synchronous, active low; the queue comes up empty.
// ----------------------------------------------------------------------------
// fifo_queue_with_lcg_batch_fill_unit
// Ring-buffer FIFO of 32-bit words in a RAM, with LCG-driven batch fill.
// ----------------------------------------------------------------------------
module fifo_queue_with_lcg_batch_fill_unit #(
  parameter int unsigned DEPTH = fqlcg_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // value, batch_count, range_min, range_max, start_seed
  input  logic [fqlcg_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [fqlcg_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // word_out, empty_flag, words_added, zero fill
  output logic [fqlcg_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [fqlcg_pkg::STAT_W-1:0]     out_tuser
);
  import fqlcg_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              pop_r, pop_nxt;
  logic [COUNT_W-1:0] remain_r, remain_nxt;
  stat_t             status_r, status_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [COUNT_W-1:0] added_r, added_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0] out_tuser_r, out_tuser_nxt;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  gen_ctrl_t         gen_ctrl;
  gen_stat_t         gen_stat;

  op_t               in_op;
  logic [WORD_W-1:0] in_value, in_min, in_max, in_seed;
  logic [COUNT_W-1:0] in_count;
  logic              full;

  assign in_op    = op_t'(in_tuser);
  assign in_value = in_tdata[VAL_LSB +: WORD_W];
  assign in_count = in_tdata[CNT_LSB +: COUNT_W];
  assign in_min   = in_tdata[MIN_LSB +: WORD_W];
  assign in_max   = in_tdata[MAX_LSB +: WORD_W];
  assign in_seed  = in_tdata[SEED_LSB +: WORD_W];
  assign full     = (occ_r == OCC_W'(DEPTH));

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  fqlcg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (tail_r),
    .wdata   (ram_wdata),
    .raddr   (head_r),
    .rdata_r (ram_rdata)
  );

  fqlcg_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (gen_ctrl),
    .range_min  (in_min),
    .range_max  (in_max),
    .start_seed (in_seed),
    .stat       (gen_stat)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    pop_nxt        = pop_r;
    remain_nxt     = remain_r;
    status_nxt     = status_r;
    word_nxt       = word_r;
    added_nxt      = added_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_wdata      = gen_stat.word;
    gen_ctrl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          status_nxt = STAT_OK;
          word_nxt   = '0;
          added_nxt  = '0;
          state_nxt  = ST_DONE;
          case (in_op)
            OP_ENQ: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = in_value;
                tail_nxt  = wrap_inc(tail_r);
                occ_nxt   = occ_r + OCC_W'(1);
                added_nxt = COUNT_W'(1);
              end
            end
            OP_BATCH: begin
              gen_ctrl.load = 1'b1;
              remain_nxt    = in_count;
              if ($signed(in_max) < $signed(in_min)) begin
                status_nxt = STAT_RANGE;
              end else if (in_count != '0) begin
                state_nxt = ST_STEP;
              end
            end
            OP_DEQ, OP_FRONT: begin
              pop_nxt = (in_op == OP_DEQ);
              if (occ_r == '0) begin
                status_nxt = STAT_EMPTY;
                word_nxt   = '1;
              end else begin
                state_nxt = ST_READ;
              end
            end
            OP_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        word_nxt = ram_rdata;
        if (pop_r) begin
          head_nxt = wrap_inc(head_r);
          occ_nxt  = occ_r - OCC_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_STEP: begin
        if (full) begin
          status_nxt = STAT_FULL;
          state_nxt  = ST_DONE;
        end else begin
          gen_ctrl.step = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (gen_stat.done) begin
          ram_we     = 1'b1;
          tail_nxt   = wrap_inc(tail_r);
          occ_nxt    = occ_r + OCC_W'(1);
          added_nxt  = added_r + COUNT_W'(1);
          remain_nxt = remain_r - COUNT_W'(1);
          state_nxt  = (remain_r == COUNT_W'(1)) ? ST_DONE : ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_DATA_W - WORD_W - 1 - COUNT_W)'(0), added_r,
                            (occ_r == '0), word_r};
          out_tuser_nxt  = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      occ_r        <= occ_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    pop_r       <= pop_nxt;
    remain_r    <= remain_nxt;
    status_r    <= status_nxt;
    word_r      <= word_nxt;
    added_r     <= added_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/fqlcg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqlcg_checker
// Port-level checks for the FIFO queue with LCG batch fill.
// ----------------------------------------------------------------------------
module fqlcg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fqlcg_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [fqlcg_pkg::STAT_W-1:0]     out_tuser
);
  import fqlcg_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one operation at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  // empty-queue read reports -1 and an empty queue
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY) |->
      (out_tdata[WORD_W-1:0] == '1) && out_tdata[EMPTY_BIT])
    else $error("empty status with bad word or flag");

  // bad range appends nothing
  a_range_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_RANGE) |-> (out_tdata[ADDED_LSB +: COUNT_W] == '0))
    else $error("words appended on invalid range");

  // anything appended leaves the queue non-empty
  a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[ADDED_LSB +: COUNT_W] != '0) |-> !out_tdata[EMPTY_BIT])
    else $error("queue empty after append");

endmodule

bind fifo_queue_with_lcg_batch_fill_unit fqlcg_checker u_fqlcg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring-buffer FIFO with LCG batch fill. A shadow
// queue predicts every reply, and each accepted reply is compared field by
// field. A short directed pass is followed by random op mixes biased toward
// filling or draining. Both stream sides idle at random, and there are two long
// reply stalls and full drain pauses, at a fixed phase and at random.
// ----------------------------------------------------------------------------
module tb_top;
  import fqlcg_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEPTH_DEF;
  localparam int          RANDOM_OPS   = 1650;
  localparam int          PHASE_LEN    = 40;
  localparam int          SINK_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 100;
  // limit sized for the worst case op: a 64-word batch plus both stalls
  localparam longint      CYCLE_LIMIT  = 64'd16_000_000;

  localparam int FLAVOR_FILL  = 0;
  localparam int FLAVOR_DRAIN = 1;
  localparam int FLAVOR_MIX   = 2;

  typedef struct packed {
    stat_t       status;
    logic [31:0] word;
    logic        empty;
    logic [7:0]  added;
  } queue_reply_t;

  // Shadow of the queue: predicts one reply per accepted op and checks replies
  // in order.
  class fifo_shadow;
    logic [31:0]  stored_words[$];
    queue_reply_t replies_due[$];
    int errors;
    int replies_checked;
    int op_count[8];
    int batch_words;
    int full_rejects;
    int range_rejects;
    int empty_reads;

    function int replies_pending();
      return replies_due.size();
    endfunction

    function void note_op(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
      queue_reply_t reply;
      logic [31:0]  value;
      logic [31:0]  lo_bits;
      logic [31:0]  hi_bits;
      logic [31:0]  seed;
      logic [7:0]   count;
      longint       lo;
      longint       span;
      longint       gen;
      int           i;
      value   = data[VAL_LSB +: 32];
      count   = data[CNT_LSB +: 8];
      lo_bits = data[MIN_LSB +: 32];
      hi_bits = data[MAX_LSB +: 32];
      seed    = data[SEED_LSB +: 32];
      reply   = '{status: STAT_OK, word: '0, empty: 1'b0, added: '0};
      op_count[op]++;
      case (op)
        OP_ENQ: begin
          if (stored_words.size() >= QUEUE_DEPTH) begin
            reply.status = STAT_FULL;
          end else begin
            stored_words.push_back(value);
            reply.added = 8'd1;
          end
        end
        OP_BATCH: begin
          lo   = longint'($signed(lo_bits));
          span = longint'($signed(hi_bits)) - lo + 1;
          if (span <= 0) begin
            reply.status = STAT_RANGE;
          end else begin
            for (i = 0; i < count && reply.status == STAT_OK; i++) begin
              seed     = seed * LCG_MUL + LCG_ADD;
              seed[31] = 1'b0;
              gen      = lo + longint'({32'd0, seed}) % span;
              if (stored_words.size() >= QUEUE_DEPTH) begin
                reply.status = STAT_FULL;
              end else begin
                stored_words.push_back(32'(gen));
                reply.added++;
              end
            end
          end
          batch_words += reply.added;
        end
        OP_DEQ, OP_FRONT: begin
          if (stored_words.size() == 0) begin
            reply.status = STAT_EMPTY;
            reply.word   = '1;
            empty_reads++;
          end else begin
            reply.word = stored_words[0];
            if (op == OP_DEQ) stored_words.pop_front();
          end
        end
        OP_CLEAR: stored_words.delete();
        default: ;
      endcase
      if (reply.status == STAT_FULL) full_rejects++;
      if (reply.status == STAT_RANGE) range_rejects++;
      reply.empty = (stored_words.size() == 0);
      replies_due.push_back(reply);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [OUT_DATA_W-1:0] data);
      queue_reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none actual status %h data %h",
                 $time, status, data);
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("word_out", want.word, data[31:0]);
      compare_field("empty_flag", 32'(want.empty), 32'(data[EMPTY_BIT]));
      compare_field("words_added", 32'(want.added), 32'(data[ADDED_LSB +: 8]));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_W-1:0]     in_tdata;
  logic [OP_W-1:0]          in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_W-1:0]    out_tdata;
  logic [STAT_W-1:0]        out_tuser;

  fifo_shadow shadow = new();
  bit         no_idle;
  bit         sink_hold_req;
  longint     cycle_count;

  fifo_queue_with_lcg_batch_fill_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, shadow.replies_pending());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) shadow.note_op(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tuser, out_tdata);
  end

  // Reply side: random wait per transaction, plus one long hold on request.
  initial begin
    int wait_n;
    out_tready <= 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      wait_n = no_idle ? 0 : $urandom_range(0, 13);
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [31:0] value,
                         input logic [7:0] count, input logic [31:0] lo,
                         input logic [31:0] hi, input logic [31:0] seed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {seed, hi, lo, count, value};
    do @(posedge clk); while (!in_tready);
  endtask

  // step past the current edge first so the transaction taken there is counted
  task automatic wait_replies_drained();
    @(posedge clk);
    while (shadow.replies_pending() != 0) @(posedge clk);
  endtask

  function automatic void draw_range(output logic [31:0] lo, output logic [31:0] hi);
    int     kind;
    longint top;
    logic [31:0] a;
    logic [31:0] b;
    kind = $urandom_range(0, 99);
    a    = $urandom;
    b    = $urandom;
    if (kind < 45) begin
      // narrow span somewhere in the signed range
      top = longint'($signed(a)) + $urandom_range(0, 1000);
      if (top > 64'sd2147483647) top = 64'sd2147483647;
      lo = a;
      hi = 32'(top);
    end else if (kind < 65) begin
      lo = ($signed(a) <= $signed(b)) ? a : b;
      hi = ($signed(a) <= $signed(b)) ? b : a;
    end else if (kind < 75) begin
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
    end else if (kind < 85) begin
      lo = a;
      hi = a;
    end else begin
      // reversed bounds; equal draws fall back to a one-value range
      lo = ($signed(a) >= $signed(b)) ? a : b;
      hi = ($signed(a) >= $signed(b)) ? b : a;
    end
  endfunction

  function automatic logic [7:0] draw_count();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) return 8'($urandom_range(0, 6));
    if (kind < 95) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(41, 255));
  endfunction

  function automatic logic [OP_W-1:0] draw_op(input int enq_w, input int batch_w,
                                              input int deq_w, input int front_w,
                                              input int empty_w, input int clear_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_w) return OP_ENQ;
    r -= enq_w;
    if (r < batch_w) return OP_BATCH;
    r -= batch_w;
    if (r < deq_w) return OP_DEQ;
    r -= deq_w;
    if (r < front_w) return OP_FRONT;
    r -= front_w;
    if (r < empty_w) return OP_EMPTY;
    r -= empty_w;
    if (r < clear_w) return OP_CLEAR;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic send_random_op(input int flavor);
    logic [OP_W-1:0] op;
    logic [31:0]     lo;
    logic [31:0]     hi;
    case (flavor)
      FLAVOR_FILL:  op = draw_op(35, 20, 25, 7, 6, 2);
      FLAVOR_DRAIN: op = draw_op(15, 8, 60, 8, 5, 1);
      default:      op = draw_op(25, 12, 38, 10, 7, 3);
    endcase
    draw_range(lo, hi);
    send_op(op, $urandom, draw_count(), lo, hi, $urandom);
  endtask

  initial begin
    int sent;
    int phase;
    int flavor;
    int i;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, word extremes, batch corner cases, full queue, unknown ops, clear
    send_op(OP_DEQ,   32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_FRONT, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_EMPTY, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_ENQ,   32'h8000_0000, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_ENQ,   32'h7fff_ffff, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_ENQ,   32'hffff_ffff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(OP_FRONT, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_EMPTY, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_DEQ,   32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_BATCH, 32'h0, 8'd0, 32'd0, 32'd10, 32'd1);
    send_op(OP_BATCH, 32'h0, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'd7);
    send_op(OP_BATCH, 32'h0, 8'd3, 32'd5, 32'd5, 32'd99);
    send_op(OP_BATCH, 32'h0, 8'd5, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(OP_BATCH, 32'h0, 8'd255, 32'hffff_fff0, 32'd15, 32'h8000_0000);
    send_op(OP_ENQ,   32'h1234_5678, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_BATCH, 32'h0, 8'd1, 32'd0, 32'd100, 32'd0);
    send_op(3'd6,     32'hffff_ffff, 8'hff, 32'h0, 32'h0, 32'h0);
    send_op(3'd7,     32'h0, 8'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(OP_FRONT, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_CLEAR, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_EMPTY, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_op(OP_DEQ,   32'h0, 8'd0, 32'h0, 32'h0, 32'h0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_OPS) begin
      flavor  = $urandom_range(0, 2);
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 3 || $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        wait_replies_drained();
      end
      if (phase == 6 || phase == 25) begin
        // long reply stall while ops keep coming back to back
        sink_hold_req = 1'b1;
        no_idle       = 1'b1;
      end
      for (i = 0; i < PHASE_LEN; i++) send_random_op(flavor);
      sent += PHASE_LEN;
      phase++;
    end
    in_tvalid <= 1'b0;
    no_idle   = 1'b0;

    wait_replies_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d replies: enq %0d, batch %0d (%0d words), deq %0d, front %0d",
             shadow.replies_checked, shadow.op_count[OP_ENQ], shadow.op_count[OP_BATCH],
             shadow.batch_words, shadow.op_count[OP_DEQ], shadow.op_count[OP_FRONT]);
    $display("is-empty %0d, clear %0d, unknown %0d; full %0d, bad range %0d, empty reads %0d",
             shadow.op_count[OP_EMPTY], shadow.op_count[OP_CLEAR],
             shadow.op_count[6] + shadow.op_count[7], shadow.full_rejects,
             shadow.range_rejects, shadow.empty_reads);
    if (shadow.errors == 0 && shadow.replies_pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fqlcg_pkg.sv
rtl/fqlcg_ram.sv
rtl/fqlcg_gen.sv
rtl/fifo_queue_with_lcg_batch_fill_unit.sv
rtl/fqlcg_checker.sv
tb/sv/tb_top.sv
